### hdl/nct_pkg.sv
// Shared types and constants for the note confirm / deviation tracker.
// No dependencies; imported by the tracker core.
package nct_pkg;

  localparam int NOTE_W    = 4;
  localparam int DEV_W     = 16;
  localparam int FREQ_W    = 24;
  localparam int CNT_W     = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int TDATA_W   = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT    = 1'd1;

  localparam logic [CNT_W-1:0]  CNT_MAX       = 8'hFF;
  localparam logic [CFG_W-1:0]  LIMIT_RESET   = 8'd3;
  localparam logic [NOTE_W-1:0] CAND_NONE     = 4'hF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DROP,
    ST_PUSH,
    ST_DIV,
    ST_OUT
  } nct_state_t;

endpackage

### hdl/nct_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle.
// Truncates toward zero. No package dependencies.
module nct_div #(
  parameter int NUM_W = 21,
  parameter int DEN_W = 5,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,   // two's complement dividend
  input  logic [DEN_W-1:0] den,   // unsigned divisor, nonzero
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic             neg_r;
  logic [NUM_W-1:0] quo_r;
  logic [DEN_W:0]   rem_r;
  logic [DEN_W-1:0] den_r;

  logic [DEN_W:0]   rem_sh;
  logic             ge;
  logic [NUM_W-1:0] num_mag;
  logic [NUM_W-1:0] quo_full;

  assign num_mag = num[NUM_W-1] ? (~num + 1'b1) : num;
  assign rem_sh  = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_comb begin
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      quo_r <= num_mag;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? (rem_sh - {1'b0, den_r}) : rem_sh;
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  // restore the sign once the magnitude is done
  assign quo_full = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quo      = quo_full[Q_W-1:0];
  assign done     = done_r;

endmodule

### hdl/note_confirm_deviation_tracker_core.sv
// Note confirm / deviation tracker top level.
// Depends on nct_pkg and nct_div.
//
// Usage: one input beat per analysis block. in_tuser[0] is the detected
// flag; in_tdata carries note, octave, Q1.15 deviation and Q16.8 frequency.
// Every input beat produces exactly one output beat: out_tuser holds the
// updated and found flags, out_tdata the published note, octave, mean
// deviation and frequency (all zero while found is low).
// The recent deviations sit in a single-port ring memory with registered
// read; when the window is full the sequencer reads the oldest entry and
// drops it, then writes the new one and, if the note is confirmed, runs an
// iterative divide for the mean. A miss or a changed note goes from EVAL
// straight to OUT; a matching item passes EVAL, DROP (only when the window
// is full) and PUSH, then the bit-serial divide DIV when it publishes.
// in_tready is high only while the sequencer is idle. A result waits in the
// output register while the receiver stalls; the next item is still taken
// and held back only at its own output step.
// Reset (rst_n low, synchronous) clears candidate, counters, window and
// published result and loads both limits with 3. Ring entries are not cleared.
module note_confirm_deviation_tracker_core #(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [nct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nct_pkg::CFG_W-1:0]     cfg_wdata,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [nct_pkg::TDATA_W-1:0]   in_tdata,  // note[3:0] octave[7:4] dev[23:8] freq[47:24]
  input  logic                          in_tuser,  // detected[0]
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [nct_pkg::TDATA_W-1:0]   out_tdata, // note[3:0] octave[7:4] mean[23:8] freq[47:24]
  output logic [1:0]                    out_tuser  // updated[0] found[1]
);

  import nct_pkg::*;

  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = IDX_W + 1;
  localparam int TOT_W  = DEV_W + 1 + $clog2(WINDOW_DEPTH);
  localparam int EXT_W  = TOT_W - DEV_W;

  nct_state_t state_r, state_nxt;

  // configuration
  logic [CFG_W-1:0] confirm_limit_r, miss_limit_r;

  // captured item
  logic              det_r;
  logic [NOTE_W-1:0] note_r, oct_r;
  logic [DEV_W-1:0]  dev_r;
  logic [FREQ_W-1:0] freq_r;

  // tracker state
  logic              cand_valid_r, cand_valid_nxt;
  logic [NOTE_W-1:0] cand_note_r, cand_note_nxt;
  logic [NOTE_W-1:0] cand_oct_r, cand_oct_nxt;
  logic [CNT_W-1:0]  conf_cnt_r, conf_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic              confirmed_r, confirmed_nxt;
  logic              upd_r, upd_nxt;

  logic              pub_found_r, pub_found_nxt;
  logic [NOTE_W-1:0] pub_note_r, pub_note_nxt;
  logic [NOTE_W-1:0] pub_oct_r, pub_oct_nxt;
  logic [DEV_W-1:0]  pub_dev_r, pub_dev_nxt;
  logic [FREQ_W-1:0] pub_freq_r, pub_freq_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]         out_user_r, out_user_nxt;

  // ring memory
  logic [DEV_W-1:0] ring_mem [WINDOW_DEPTH];
  logic [DEV_W-1:0] rd_data_r;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] wr_addr;

  // helpers
  logic             accept;
  logic             match;
  logic             full;
  logic             mp_clear;
  logic             slot_free;
  logic [TOT_W-1:0] dev_ext, rd_ext;
  logic [SUM_W-1:0] tail_sum;
  logic [IDX_W-1:0] tail_idx;
  logic [IDX_W-1:0] head_inc;

  logic             div_start;
  logic             div_done;
  logic [DEV_W-1:0] div_quo;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign match     = cand_valid_r && (note_r == cand_note_r) && (oct_r == cand_oct_r);
  assign full      = (fill_r == FILL_W'(WINDOW_DEPTH));
  assign mp_clear  = (miss_cnt_r >= miss_limit_r);
  assign slot_free = !out_valid_r || out_tready;
  assign dev_ext   = {{EXT_W{dev_r[DEV_W-1]}}, dev_r};
  assign rd_ext    = {{EXT_W{rd_data_r[DEV_W-1]}}, rd_data_r};
  assign tail_sum  = {1'b0, head_r} + SUM_W'(fill_r);
  assign tail_idx  = (tail_sum >= SUM_W'(WINDOW_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(WINDOW_DEPTH)) : IDX_W'(tail_sum);
  assign head_inc  = (head_r == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head_r + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (det_r && match) begin
          state_nxt = full ? ST_DROP : ST_PUSH;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DROP: state_nxt = ST_PUSH;
      ST_PUSH: state_nxt = confirmed_r ? ST_DIV : ST_OUT;
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    cand_valid_nxt = cand_valid_r;
    cand_note_nxt  = cand_note_r;
    cand_oct_nxt   = cand_oct_r;
    conf_cnt_nxt   = conf_cnt_r;
    miss_cnt_nxt   = miss_cnt_r;
    head_nxt       = head_r;
    fill_nxt       = fill_r;
    total_nxt      = total_r;
    confirmed_nxt  = confirmed_r;
    upd_nxt        = upd_r;
    pub_found_nxt  = pub_found_r;
    pub_note_nxt   = pub_note_r;
    pub_oct_nxt    = pub_oct_r;
    pub_dev_nxt    = pub_dev_r;
    pub_freq_nxt   = pub_freq_r;
    out_data_nxt   = out_data_r;
    out_user_nxt   = out_user_r;
    out_valid_nxt  = out_valid_r;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    wr_addr        = tail_idx;
    div_start      = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_EVAL: begin
        upd_nxt = 1'b0;
        if (det_r && match) begin
          confirmed_nxt = (conf_cnt_r >= confirm_limit_r);
          conf_cnt_nxt  = (conf_cnt_r == CNT_MAX) ? conf_cnt_r : conf_cnt_r + 1'b1;
          mem_re        = full;
        end else begin
          // miss path, shared by no detection and a changed note
          if (mp_clear) begin
            conf_cnt_nxt = '0;
            if (pub_found_r) begin
              pub_found_nxt = 1'b0;
              head_nxt      = '0;
              fill_nxt      = '0;
              total_nxt     = '0;
              upd_nxt       = 1'b1;
            end
          end
          miss_cnt_nxt = (miss_cnt_r == CNT_MAX) ? miss_cnt_r : miss_cnt_r + 1'b1;
          if (det_r) begin
            // new candidate: restart the window with this deviation
            cand_valid_nxt = 1'b1;
            cand_note_nxt  = note_r;
            cand_oct_nxt   = oct_r;
            conf_cnt_nxt   = '0;
            head_nxt       = '0;
            fill_nxt       = FILL_W'(1);
            total_nxt      = dev_ext;
            mem_we         = 1'b1;
            wr_addr        = '0;
          end
        end
      end
      ST_DROP: begin
        // oldest entry is on the read port now
        total_nxt = total_r - rd_ext;
        head_nxt  = head_inc;
        fill_nxt  = FILL_W'(WINDOW_DEPTH - 1);
      end
      ST_PUSH: begin
        mem_we    = 1'b1;
        fill_nxt  = fill_r + 1'b1;
        total_nxt = total_r + dev_ext;
        div_start = confirmed_r;
      end
      ST_DIV: begin
        if (div_done) begin
          miss_cnt_nxt  = '0;
          pub_found_nxt = 1'b1;
          pub_note_nxt  = note_r;
          pub_oct_nxt   = oct_r;
          pub_dev_nxt   = div_quo;
          pub_freq_nxt  = freq_r;
          upd_nxt       = 1'b1;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = {pub_found_r, upd_r};
          out_data_nxt  = pub_found_r ? {pub_freq_r, pub_dev_r, pub_oct_r, pub_note_r} : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      confirm_limit_r <= LIMIT_RESET;
      miss_limit_r    <= LIMIT_RESET;
      cand_valid_r    <= 1'b0;
      cand_note_r     <= CAND_NONE;
      cand_oct_r      <= CAND_NONE;
      conf_cnt_r      <= '0;
      miss_cnt_r      <= '0;
      head_r          <= '0;
      fill_r          <= '0;
      total_r         <= '0;
      confirmed_r     <= 1'b0;
      upd_r           <= 1'b0;
      pub_found_r     <= 1'b0;
      pub_note_r      <= '0;
      pub_oct_r       <= '0;
      pub_dev_r       <= '0;
      pub_freq_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cand_valid_r <= cand_valid_nxt;
      cand_note_r  <= cand_note_nxt;
      cand_oct_r   <= cand_oct_nxt;
      conf_cnt_r   <= conf_cnt_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
      head_r       <= head_nxt;
      fill_r       <= fill_nxt;
      total_r      <= total_nxt;
      confirmed_r  <= confirmed_nxt;
      upd_r        <= upd_nxt;
      pub_found_r  <= pub_found_nxt;
      pub_note_r   <= pub_note_nxt;
      pub_oct_r    <= pub_oct_nxt;
      pub_dev_r    <= pub_dev_nxt;
      pub_freq_r   <= pub_freq_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_CONFIRM_LIMIT: confirm_limit_r <= cfg_wdata;
          CFG_MISS_LIMIT:    miss_limit_r    <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // item capture and output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      det_r  <= in_tuser;
      note_r <= in_tdata[3:0];
      oct_r  <= in_tdata[7:4];
      dev_r  <= in_tdata[23:8];
      freq_r <= in_tdata[47:24];
    end
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  // ring memory: reads and writes fall in different steps, so no forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[wr_addr] <= dev_r;
    end
    if (mem_re) begin
      rd_data_r <= ring_mem[head_r];
    end
  end

  nct_div #(
    .NUM_W (TOT_W),
    .DEN_W (FILL_W),
    .Q_W   (DEV_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (total_nxt),
    .den   (fill_nxt),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill exceeds depth");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside divide step");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("second item taken while one is in flight");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r[1]) |-> (out_data_r == '0))
    else $error("result payload not cleared while nothing is published");

endmodule
